// ----- rtl/core/css_pkg.sv -----
// ----------------------------------------------------------------------------
// css_pkg
// Shared sizes and types of the shaker sort core.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int MAX_ELEMENTS = 32;
  localparam int VALUE_W      = 32;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  // one classified element on its way from front to back
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      keep;
  } css_entry_t;

endpackage

// ----- rtl/core/css_if.sv -----
// ----------------------------------------------------------------------------
// css_if
// Valid/ready channels of the shaker sort core.
// ----------------------------------------------------------------------------
interface css_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface css_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sorted_value;
  logic               last_out;
  logic               dropped;

  modport source (output valid, output sorted_value, output last_out, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input dropped,
                  output ready);
endinterface

// ----- rtl/core/css_front.sv -----
// ----------------------------------------------------------------------------
// css_front
// Accepts elements and marks each one as kept or dropped by store capacity.
// ----------------------------------------------------------------------------
module css_front
  import css_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  css_in_if.sink     item,
  output css_entry_t push_data,
  output logic       push_valid,
  input  logic       push_ready
);

  logic [CNT_W-1:0] fill;
  logic             keep;
  logic             take;

  assign keep       = (fill < CNT_W'(MAX_ELEMENTS));
  assign take       = item.valid && push_ready;
  assign item.ready = push_ready;
  assign push_valid = item.valid;

  always_comb begin
    push_data.value = item.value;
    push_data.last  = item.last;
    push_data.keep  = keep;
  end

  // fill tracks the elements kept in the open set
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (take) begin
      if (item.last) begin
        fill <= '0;
      end else if (keep) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/css_queue.sv -----
// ----------------------------------------------------------------------------
// css_queue
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module css_queue
  import css_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  css_entry_t push_data,
  input  logic       push_valid,
  output logic       push_ready,
  output css_entry_t pop_data,
  output logic       pop_valid,
  input  logic       pop_ready
);

  css_entry_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   level;
  logic              push;
  logic              pop;

  assign push_ready = (level != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (level != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        level <= level - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/core/css_back.sv -----
// ----------------------------------------------------------------------------
// css_back
// Compare-exchange cell chain: inserts each kept element in order, then
// drains the sorted set through an output register.
// ----------------------------------------------------------------------------
module css_back
  import css_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  css_entry_t pop_data,
  input  logic       pop_valid,
  output logic       pop_ready,
  css_out_if.source  result
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                      state;
  logic [CNT_W-1:0]          count;
  logic                      ovf;
  logic signed [VALUE_W-1:0] cells [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0]   below;
  logic                      pop;
  logic [CNT_W-1:0]          count_next;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_last;
  logic                      out_dropped;
  logic                      emit;

  assign pop_ready           = (state == ST_LOAD);
  assign pop                 = pop_valid && pop_ready;
  assign emit                = (state == ST_DRAIN) && (!out_valid || result.ready);
  assign count_next          = count + CNT_W'(pop_data.keep);
  assign result.valid        = out_valid;
  assign result.sorted_value = out_value;
  assign result.last_out     = out_last;
  assign result.dropped      = out_dropped;

  // cells already in order that stay ahead of the new element
  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      below[i] = (CNT_W'(i) < count) && (cells[i] <= pop_data.value);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_data.keep) begin
      if (!below[0]) begin
        cells[0] <= pop_data.value;
      end
      for (int i = 1; i < MAX_ELEMENTS; i++) begin
        if (!below[i]) begin
          if (below[i-1]) begin
            cells[i] <= pop_data.value;
          end else begin
            cells[i] <= cells[i-1];
          end
        end
      end
    end else if (emit) begin
      for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
        cells[i] <= cells[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value   <= cells[0];
      out_last    <= (count == CNT_W'(1));
      out_dropped <= ovf && (count == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (pop) begin
            if (pop_data.last) begin
              count <= count_next;
              if (count_next == '0) begin
                ovf <= 1'b0;
              end else begin
                ovf   <= ovf || !pop_data.keep;
                state <= ST_DRAIN;
              end
            end else begin
              count <= count_next;
              ovf   <= ovf || !pop_data.keep;
            end
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            count <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              ovf   <= 1'b0;
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count above capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (count != '0))
    else $error("draining with no element left");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && ovf) |-> (count == CNT_W'(MAX_ELEMENTS)))
    else $error("drop recorded while store not full");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    (emit && count == CNT_W'(1)) |=> (state == ST_LOAD && out_last))
    else $error("final element did not close the drain");

endmodule

// ----- rtl/core/cocktail_shaker_sort_core.sv -----
// ----------------------------------------------------------------------------
// cocktail_shaker_sort_core
// Collects a set of signed 32-bit elements and returns them in ascending order.
// ----------------------------------------------------------------------------
// An element is taken every cycle while a set loads: each kept element is
// inserted into a 32-cell compare-exchange chain, behind a two-entry queue.
// The element with last set closes the set; its sorted elements then leave
// one per cycle while the receiver is ready, from the head of the chain
// through the output register, the final one marked by last_out. Elements
// arriving once 32 are held are discarded and reported by dropped on the
// final result. A set with no stored element gives no result. While a set
// drains, up to two new elements are taken into the queue; after that new
// elements wait.
module cocktail_shaker_sort_core
  import css_pkg::*;
(
  input logic       clk,
  input logic       rst,
  css_in_if.sink    item,
  css_out_if.source result
);

  css_entry_t push_data;
  logic       push_valid;
  logic       push_ready;
  css_entry_t pop_data;
  logic       pop_valid;
  logic       pop_ready;

  css_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  css_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  css_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule

// ----- test/cocktail_shaker_sort_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cocktail_shaker_sort_core_test
// Self-checking bench for the shaker sort core: sets of signed values go in,
// each closed set is sorted by the bench itself and every sorted element that
// comes out is compared against it, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module cocktail_shaker_sort_core_test;
  import css_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int LONG_HOLD       = 400;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int REPORT_MAX      = 10;
  localparam int DRAIN_CYCLES    = 64;

  typedef struct {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      dropped;
  } sorted_elem_t;

  class sorted_set_board;
    logic signed [VALUE_W-1:0] held[$];
    bit                        overflow;
    sorted_elem_t              awaited[$];
    int                        mismatches;

    function void note_element(logic signed [VALUE_W-1:0] value, logic last);
      sorted_elem_t              e;
      logic signed [VALUE_W-1:0] t;
      int                        j;
      if (held.size() < MAX_ELEMENTS) begin
        held.push_back(value);
      end else begin
        overflow = 1'b1;
      end
      if (last) begin
        for (int i = 1; i < held.size(); i++) begin
          t = held[i];
          j = i;
          while (j > 0 && held[j-1] > t) begin
            held[j] = held[j-1];
            j--;
          end
          held[j] = t;
        end
        foreach (held[k]) begin
          e.sorted_value = held[k];
          e.last_out     = (k == held.size() - 1);
          e.dropped      = e.last_out && overflow;
          awaited.push_back(e);
        end
        held.delete();
        overflow = 1'b0;
      end
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] v, logic lo, logic dr);
      sorted_elem_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result value %0d last_out %b dropped %b", $time, v, lo, dr);
        return;
      end
      e = awaited.pop_front();
      if (v !== e.sorted_value || lo !== e.last_out || dr !== e.dropped) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: expected value %0d last_out %b dropped %b, got value %0d last_out %b dropped %b",
                   $time, e.sorted_value, e.last_out, e.dropped, v, lo, dr);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst;
  logic            holding = 1'b0;
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              cycles = 0;
  int              items_sent = 0;
  event            long_hold_go;
  sorted_set_board board;

  css_in_if  item_ch();
  css_out_if result_ch();

  cocktail_shaker_sort_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver side
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst || holding) begin
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // long receiver hold-off so the core fills up and stalls its input
  always begin
    @(long_hold_go);
    holding <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      board.check_result(result_ch.sorted_value, result_ch.last_out, result_ch.dropped);
  end

  task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.value <= v;
    item_ch.last  <= l;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    board.note_element(v, l);
    items_sent++;
  endtask

  // 0: any value, 1: narrow range with many ties, 2: mostly extremes
  function automatic logic signed [VALUE_W-1:0] pick_value(int flavor);
    int r;
    if (flavor == 0)
      return $urandom;
    if (flavor == 1)
      return $urandom_range(8) - 4;
    r = $urandom_range(5);
    if (r == 0) return 32'sh7fffffff;
    if (r == 1) return 32'sh80000000;
    if (r == 2) return -1;
    if (r == 3) return 0;
    if (r == 4) return 1;
    return $urandom;
  endfunction

  task automatic send_set(input int n, input int flavor);
    for (int k = 0; k < n; k++)
      send_item(pick_value(flavor), k == n - 1);
  endtask

  task automatic random_sets(input int target);
    int first;
    int r;
    int n;
    first = items_sent;
    while (items_sent - first < target) begin
      r = $urandom_range(99);
      if (r < 70)
        n = $urandom_range(8, 1);
      else if (r < 92)
        n = $urandom_range(32, 9);
      else
        n = $urandom_range(36, 33);
      send_set(n, $urandom_range(2));
    end
  endtask

  initial begin
    board = new();
    rst           <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.value <= '0;
    item_ch.last  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // single element set
    send_item(32'sh80000000, 1'b1);
    // extremes, mixed
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b1);
    // already in order
    send_item(-3, 1'b0);
    send_item(-2, 1'b0);
    send_item(-1, 1'b0);
    send_item(0, 1'b1);
    // reverse order
    send_item(4, 1'b0);
    send_item(3, 1'b0);
    send_item(2, 1'b0);
    send_item(1, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b1);
    // ties
    send_item(7, 1'b0);
    send_item(7, 1'b0);
    send_item(-7, 1'b0);
    send_item(7, 1'b1);

    // store full when the closing element arrives, then a set queued behind it
    -> long_hold_go;
    send_set(MAX_ELEMENTS + 1, 0);
    send_set(6, 2);

    random_sets(ITEMS_PER_PHASE);
    idle_pct  = 80;
    stall_pct = 0;
    random_sets(ITEMS_PER_PHASE);
    idle_pct  = 0;
    stall_pct = 80;
    random_sets(ITEMS_PER_PHASE);
    idle_pct  = 23;
    stall_pct = 23;
    random_sets(ITEMS_PER_PHASE);
    item_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
